// ===== sv/ces_pkg.sv =====
`timescale 1ns / 1ps
// Package for the closure environment store: field widths, mode and
// status codes, and the sequencer state type. No dependencies.
package ces_pkg;

   localparam int MODE_W      = 2;
   localparam int JUMPS_W     = 10;
   localparam int STATUS_W    = 3;
   localparam int ENV_OUT_W   = 10;
   localparam int COUNT_OUT_W = 11;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GRAB   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] STS_ENV_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] STS_UNKNOWN  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GRAB,
      S_WALK
   } state_type;

endpackage

// ===== sv/ces_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// Depends on ces_pkg for field widths.
interface ces_req_if #(parameter int TERM_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic [ces_pkg::MODE_W-1:0]   mode;
   logic [TERM_BITS-1:0]         term_handle;
   logic [ces_pkg::JUMPS_W-1:0]  jumps;

   modport source (output valid, mode, term_handle, jumps, input ready);
   modport sink   (input valid, mode, term_handle, jumps, output ready);
endinterface

interface ces_rsp_if #(parameter int TERM_BITS = 32);
   logic                            valid;
   logic                            ready;
   logic [TERM_BITS-1:0]            result_term;
   logic [ces_pkg::STATUS_W-1:0]    status;
   logic [ces_pkg::ENV_OUT_W-1:0]   current_env;
   logic [ces_pkg::COUNT_OUT_W-1:0] stack_count;

   modport source (output valid, result_term, status, current_env, stack_count,
                   input ready);
   modport sink   (input valid, result_term, status, current_env, stack_count,
                   output ready);
endinterface

// ===== sv/ces_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies; contents are undefined until written.
module ces_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 42,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/closure_environment_store.sv =====
`timescale 1ns / 1ps
// Top level of the closure environment store: sequencer, closure stack
// and link table. Depends on ces_pkg, ces_if and ces_ram.
//
// Usage:
//   req_ch carries one request beat per operation: mode (push, grab,
//   access), term_handle for a push and jumps for an access. rsp_ch
//   returns exactly one response beat per request: the term found, a
//   status code, the current environment id and the stack count.
//   A push, mode 3 and a request refused at acceptance load the response
//   register directly; a grab first reads the stack RAM, and an access
//   reads the link table at its start entry and once more per hop.
//   One request is in flight at a time; ready rises again once the
//   sequencer is back at idle and the response register is free or
//   draining in the same cycle, so a new request may overlap the
//   hand-over of the previous response.
//   A stalled receiver holds the response register and with it ready.
//   Reset empties the stack, sets the next free id to one and clears the
//   current environment; both RAMs keep their contents and need no
//   clearing pass.
module closure_environment_store #(
   parameter int STACK_DEPTH = 1024,
   parameter int ENV_DEPTH   = 1023,
   parameter int TERM_BITS   = 32
) (
   input logic   clock,
   input logic   reset,
   ces_req_if.sink   req_ch,
   ces_rsp_if.source rsp_ch
);

   import ces_pkg::*;

   // Widths follow from the depths: ids index the link table directly,
   // entry zero stays unused.
   localparam int ID_W  = $clog2(ENV_DEPTH + 1);
   localparam int NF_W  = $clog2(ENV_DEPTH + 2);
   localparam int TOP_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SE_W  = TERM_BITS + ID_W;       // {term, env}
   localparam int LE_W  = TERM_BITS + 2 * ID_W;   // {term, env, next}

   state_type              state_ff, state_in;
   logic [TOP_W-1:0]       top_ff, top_in;
   logic [NF_W-1:0]        nfree_ff, nfree_in;
   logic [ID_W-1:0]        cur_ff, cur_in;
   logic [JUMPS_W-1:0]     cnt_ff, cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TERM_BITS-1:0]   res_term_ff, res_term_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [ENV_OUT_W-1:0]   res_env_ff, res_env_in;
   logic [COUNT_OUT_W-1:0] res_count_ff, res_count_in;

   logic                   st_we, st_re;
   logic [SA_W-1:0]        st_waddr, st_raddr;
   logic [SE_W-1:0]        st_wdata, st_rdata;
   logic                   lk_we, lk_re;
   logic [ID_W-1:0]        lk_waddr, lk_raddr;
   logic [LE_W-1:0]        lk_wdata, lk_rdata;

   logic                   req_acc;
   logic                   stack_full, env_full, cur_ok, next_ok;
   logic [TOP_W-1:0]       top_inc, top_dec;
   logic [ID_W-1:0]        l_next, l_env, s_env;
   logic [TERM_BITS-1:0]   l_term, s_term;

   function automatic logic id_valid(input logic [ID_W-1:0] id);
      return (id != '0) && (32'(id) <= 32'(ENV_DEPTH));
   endfunction

   ces_ram #(.DEPTH(STACK_DEPTH), .WIDTH(SE_W), .AW(SA_W)) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   ces_ram #(.DEPTH(ENV_DEPTH + 1), .WIDTH(LE_W), .AW(ID_W)) u_links (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_en   (lk_re),
      .rd_addr (lk_raddr),
      .rd_data (lk_rdata)
   );

   // Decode of stored entries and the shared compare/step terms.
   assign s_term     = st_rdata[SE_W-1:ID_W];
   assign s_env      = st_rdata[ID_W-1:0];
   assign l_term     = lk_rdata[LE_W-1:2*ID_W];
   assign l_env      = lk_rdata[2*ID_W-1:ID_W];
   assign l_next     = lk_rdata[ID_W-1:0];
   assign top_inc    = top_ff + 1'b1;
   assign top_dec    = top_ff - 1'b1;
   assign stack_full = 32'(top_ff) >= 32'(STACK_DEPTH);
   assign env_full   = 32'(nfree_ff) > 32'(ENV_DEPTH);
   assign cur_ok     = id_valid(cur_ff);
   assign next_ok    = id_valid(l_next);

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_acc      = req_ch.valid && req_ch.ready;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_ch.mode == MODE_GRAB && !env_full && top_ff != '0) begin
                  state_in = S_GRAB;
               end else if (req_ch.mode == MODE_ACCESS && cur_ok) begin
                  state_in = S_WALK;
               end
            end
         end
         S_GRAB: state_in = S_IDLE;
         S_WALK: begin
            if (cnt_ff == '0 || !next_ok) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, RAM controls and response register loads.
   always_comb begin
      top_in        = top_ff;
      nfree_in      = nfree_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      res_term_in   = res_term_ff;
      res_status_in = res_status_ff;
      res_env_in    = res_env_ff;
      res_count_in  = res_count_ff;
      st_we         = 1'b0;
      st_re         = 1'b0;
      st_waddr      = top_ff[SA_W-1:0];
      st_raddr      = top_dec[SA_W-1:0];
      st_wdata      = {req_ch.term_handle, cur_ff};
      lk_we         = 1'b0;
      lk_re         = 1'b0;
      lk_waddr      = nfree_ff[ID_W-1:0];
      lk_wdata      = {s_term, s_env, cur_ff};
      lk_raddr      = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               // Default response: nothing changes, status ok.
               rsp_valid_in  = 1'b1;
               res_term_in   = '0;
               res_status_in = STS_OK;
               res_env_in    = ENV_OUT_W'(cur_ff);
               res_count_in  = COUNT_OUT_W'(top_ff);
               case (req_ch.mode)
                  MODE_PUSH: begin
                     if (stack_full) begin
                        res_status_in = STS_OVERFLOW;
                     end else begin
                        st_we        = 1'b1;
                        top_in       = top_inc;
                        res_count_in = COUNT_OUT_W'(top_inc);
                     end
                  end
                  MODE_GRAB: begin
                     if (env_full) begin
                        res_status_in = STS_ENV_FULL;
                     end else if (top_ff == '0) begin
                        res_status_in = STS_EMPTY;
                     end else begin
                        // Fetch the top closure; respond once it lands.
                        rsp_valid_in = 1'b0;
                        st_re        = 1'b1;
                     end
                  end
                  MODE_ACCESS: begin
                     if (!cur_ok) begin
                        res_status_in = STS_UNKNOWN;
                     end else begin
                        rsp_valid_in = 1'b0;
                        lk_re        = 1'b1;
                        cnt_in       = req_ch.jumps;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_GRAB: begin
            // Link the popped closure into a fresh entry and make it current.
            lk_we         = 1'b1;
            cur_in        = nfree_ff[ID_W-1:0];
            nfree_in      = nfree_ff + 1'b1;
            top_in        = top_dec;
            rsp_valid_in  = 1'b1;
            res_term_in   = '0;
            res_status_in = STS_OK;
            res_env_in    = ENV_OUT_W'(nfree_ff[ID_W-1:0]);
            res_count_in  = COUNT_OUT_W'(top_dec);
         end
         S_WALK: begin
            lk_raddr = l_next;
            if (cnt_ff == '0) begin
               // Arrived: hand back the term and adopt its environment.
               cur_in        = l_env;
               rsp_valid_in  = 1'b1;
               res_term_in   = l_term;
               res_status_in = STS_OK;
               res_env_in    = ENV_OUT_W'(l_env);
               res_count_in  = COUNT_OUT_W'(top_ff);
            end else if (!next_ok) begin
               // Chain ran out early: drop the walk, state untouched.
               rsp_valid_in  = 1'b1;
               res_term_in   = '0;
               res_status_in = STS_UNKNOWN;
               res_env_in    = ENV_OUT_W'(cur_ff);
               res_count_in  = COUNT_OUT_W'(top_ff);
            end else begin
               // Advance one link.
               lk_re  = 1'b1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         nfree_ff     <= NF_W'(1);
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         nfree_ff     <= nfree_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      res_term_ff   <= res_term_in;
      res_status_ff <= res_status_in;
      res_env_ff    <= res_env_in;
      res_count_ff  <= res_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_term = res_term_ff;
   assign rsp_ch.status      = res_status_ff;
   assign rsp_ch.current_env = res_env_ff;
   assign rsp_ch.stack_count = res_count_ff;

   // The current environment is always an id already handed out.
   a_cur_allocated: assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) < 32'(nfree_ff))
      else $error("current environment beyond allocated ids");

   // The stack pointer never passes the depth.
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) <= 32'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   // A push that fits grows the stack by one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.mode == MODE_PUSH && !stack_full)
      |=> (top_ff == $past(top_ff) + 1'b1))
      else $error("push did not advance stack pointer");

   // While the sequencer is busy the response register stays empty.
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending during multi-cycle operation");

   // A walk only ever runs from a valid current environment.
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && state_in == S_WALK) |-> cur_ok)
      else $error("walk started without a current environment");

endmodule

// ===== dv/closure_environment_store_checker.sv =====
`timescale 1ns / 1ps
// Checker for the closure environment store: watches both channels, predicts each response
// beat and compares it field by field. Depends on ces_pkg and ces_if.
module closure_environment_store_checker
   import ces_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int ENV_DEPTH   = 1023,
   parameter int TERM_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   ces_req_if          req,
   ces_rsp_if          rsp,
   output int unsigned mismatches,
   output int unsigned pending,
   output int unsigned compared,
   output logic [4:0]  status_seen
);

   localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef struct packed {
      logic [TERM_BITS-1:0]   term;
      logic [STATUS_W-1:0]    status;
      logic [ENV_OUT_W-1:0]   env;
      logic [COUNT_OUT_W-1:0] count;
   } outcome_type;

   // shadow copy of the store
   logic [TERM_BITS-1:0] stack_term [STACK_DEPTH];
   logic [ENV_OUT_W-1:0] stack_env  [STACK_DEPTH];
   logic [TERM_BITS-1:0] link_term  [ENV_DEPTH+1];
   logic [ENV_OUT_W-1:0] link_env   [ENV_DEPTH+1];
   logic [ENV_OUT_W-1:0] link_next  [ENV_DEPTH+1];
   logic [COUNT_OUT_W-1:0] top_ptr = '0;
   logic [COUNT_OUT_W-1:0] next_id = COUNT_OUT_W'(1);
   logic [ENV_OUT_W-1:0]   cur_id  = '0;

   outcome_type outcomes_due [$];
   int unsigned fail_total = 0;
   int unsigned seen_total = 0;
   logic [4:0]  codes_seen = '0;

   function automatic logic env_known(input logic [ENV_OUT_W-1:0] id);
      return id != 0 && int'(id) <= ENV_DEPTH;
   endfunction

   // advance the shadow store by one operation and return its response
   function automatic outcome_type apply_operation(input logic [MODE_W-1:0] mode,
                                                   input logic [TERM_BITS-1:0] term,
                                                   input logic [JUMPS_W-1:0] jumps);
      outcome_type          o;
      logic [ENV_OUT_W-1:0] id;
      logic                 ok;
      int                   i;
      o = '0;
      o.status = STS_OK;
      case (mode)
         MODE_PUSH: begin
            if (int'(top_ptr) >= STACK_DEPTH) begin
               o.status = STS_OVERFLOW;
            end else begin
               stack_term[top_ptr[SA_W-1:0]] = term;
               stack_env[top_ptr[SA_W-1:0]]  = cur_id;
               top_ptr++;
            end
         end
         MODE_GRAB: begin
            // running out of ids wins over an empty stack
            if (int'(next_id) > ENV_DEPTH) begin
               o.status = STS_ENV_FULL;
            end else if (top_ptr == 0) begin
               o.status = STS_EMPTY;
            end else begin
               top_ptr--;
               link_term[next_id[ENV_OUT_W-1:0]] = stack_term[top_ptr[SA_W-1:0]];
               link_env[next_id[ENV_OUT_W-1:0]]  = stack_env[top_ptr[SA_W-1:0]];
               link_next[next_id[ENV_OUT_W-1:0]] = cur_id;
               cur_id = next_id[ENV_OUT_W-1:0];
               next_id++;
            end
         end
         MODE_ACCESS: begin
            id = cur_id;
            ok = env_known(id);
            for (i = 0; ok && i < int'(jumps); i++) begin
               id = link_next[id];
               ok = env_known(id);
            end
            if (!ok) begin
               o.status = STS_UNKNOWN;
            end else begin
               o.term = link_term[id];
               cur_id = link_env[id];
            end
         end
         default: ;
      endcase
      o.env   = cur_id;
      o.count = top_ptr;
      return o;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         top_ptr = '0;
         next_id = COUNT_OUT_W'(1);
         cur_id  = '0;
         outcomes_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (outcomes_due.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_total++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("result_term", 64'(want.term), 64'(rsp.result_term));
               check_field("status", 64'(want.status), 64'(rsp.status));
               check_field("current_env", 64'(want.env), 64'(rsp.current_env));
               check_field("stack_count", 64'(want.count), 64'(rsp.stack_count));
               seen_total++;
               if (rsp.status <= STS_EMPTY) codes_seen[rsp.status] = 1'b1;
            end
         end
         if (req.valid && req.ready)
            outcomes_due.push_back(apply_operation(req.mode, req.term_handle, req.jumps));
      end
      mismatches  <= fail_total;
      pending     <= outcomes_due.size();
      compared    <= seen_total;
      status_seen <= codes_seen;
   end

endmodule

// ===== dv/closure_environment_store_tb.sv =====
`timescale 1ns / 1ps
// Top of the closure environment store testbench: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on ces_pkg, ces_if and the checker.
module closure_environment_store_tb;
   import ces_pkg::*;

   localparam int TERM_BITS = 32;
   // the fourth mode code has no meaning and must leave the store untouched
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

   logic clock;
   logic reset;

   ces_req_if #(.TERM_BITS(TERM_BITS)) req_ch ();
   ces_rsp_if #(.TERM_BITS(TERM_BITS)) rsp_ch ();

   int unsigned mismatches;
   int unsigned pending;
   int unsigned compared;
   logic [4:0]  status_seen;

   // idling odds in percent, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int unsigned beats_per_mode [4] = '{0, 0, 0, 0};

   closure_environment_store #(
      .STACK_DEPTH(1024),
      .ENV_DEPTH  (1023),
      .TERM_BITS  (TERM_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   closure_environment_store_checker #(
      .STACK_DEPTH(1024),
      .ENV_DEPTH  (1023),
      .TERM_BITS  (TERM_BITS)
   ) chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .mismatches (mismatches),
      .pending    (pending),
      .compared   (compared),
      .status_seen(status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: decide ready afresh every cycle; hold it low with the current odds.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Drive one request beat and return at the edge that accepts it. Idle cycles come
   // first, so valid is only ever written once per edge: dropped for a gap, or kept
   // high straight into the next beat.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [TERM_BITS-1:0] term,
                               input logic [JUMPS_W-1:0] jumps);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.term_handle <= term;
      req_ch.jumps       <= jumps;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_per_mode[mode]++;
   endtask

   // Random beat: mostly pushes and grabs that build environment chains, with accesses
   // that mostly take short hops so they land inside the chain. A few hops cover the
   // whole index range, and the odd meaningless mode goes in as noise.
   task automatic random_request();
      int                 pick;
      int                 reach;
      logic [MODE_W-1:0]  mode;
      logic [JUMPS_W-1:0] jumps;
      pick  = $urandom_range(0, 99);
      reach = $urandom_range(0, 9);
      if (pick < 40)      mode = MODE_PUSH;
      else if (pick < 70) mode = MODE_GRAB;
      else if (pick < 95) mode = MODE_ACCESS;
      else                mode = MODE_IGNORED;
      if (reach < 7)      jumps = JUMPS_W'($urandom_range(0, 3));
      else if (reach < 9) jumps = JUMPS_W'($urandom_range(0, 15));
      else                jumps = JUMPS_W'($urandom_range(0, 1023));
      send_request(mode, $urandom, jumps);
   endtask

   // Short directed opening from the reset state: empty-store errors, both term
   // extremes, a small chain walked at several depths, and the index extremes.
   task automatic directed_opening();
      send_request(MODE_ACCESS, 32'h0, 10'd0);            // no current environment
      send_request(MODE_GRAB, 32'h0, 10'd0);              // grab on an empty stack
      send_request(MODE_IGNORED, 32'hFFFF_FFFF, 10'h3FF);
      send_request(MODE_PUSH, 32'h0000_0000, 10'h3FF);
      send_request(MODE_PUSH, 32'hFFFF_FFFF, 10'h000);
      send_request(MODE_PUSH, 32'hA5A5_A5A5, 10'h2AA);
      send_request(MODE_GRAB, 32'h0, 10'd0);
      send_request(MODE_GRAB, 32'h0, 10'd0);
      send_request(MODE_PUSH, 32'h5A5A_5A5A, 10'h155);
      send_request(MODE_GRAB, 32'h0, 10'd0);
      send_request(MODE_ACCESS, 32'h0, 10'd3);            // chain runs out
      send_request(MODE_ACCESS, 32'h0, 10'd1);
      send_request(MODE_ACCESS, 32'h0, 10'd0);            // current environment is id 0 again
      send_request(MODE_PUSH, 32'h8000_0001, 10'd0);
      send_request(MODE_GRAB, 32'h0, 10'd0);
      send_request(MODE_ACCESS, 32'h0, 10'd0);
      send_request(MODE_ACCESS, 32'h0, 10'h3FF);          // deepest index
      send_request(MODE_GRAB, 32'h0, 10'd0);
      send_request(MODE_IGNORED, 32'h0, 10'd0);
   endtask

   initial begin
      int phase;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_PUSH;
      req_ch.term_handle <= '0;
      req_ch.jumps       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // three phases: sender gappy and receiver stalling hard, then swapped, then flat out
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) directed_opening();
         repeat (217) random_request();
      end
      req_ch.valid <= 1'b0;

      // let the checker see the last beat, drain, then allow the longest walk to settle
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (1100) @(posedge clock);

      if (pending != 0) $error("%0d responses never arrived", pending);
      $display("covered %0d push, %0d grab, %0d access and %0d ignored request beats",
               beats_per_mode[MODE_PUSH], beats_per_mode[MODE_GRAB],
               beats_per_mode[MODE_ACCESS], beats_per_mode[MODE_IGNORED]);
      $display("%0d responses compared; status codes returned (code 4 down to 0): %b",
               compared, status_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: a healthy run ends well inside this.
   initial begin
      #40ms;
      $display("watchdog expired with %0d responses outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
